### hw/rtl/sida_pkg.sv
// Shared constants, types and helpers for the signed integer to decimal ASCII unit.
package sida_pkg;

    localparam int VALUE_W       = 32;
    localparam int CODE_W        = 6;
    localparam int TDATA_IN_W    = 32;
    localparam int TDATA_OUT_W   = 8;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(NUM_STEPS);
    localparam int IDX_W         = $clog2(NUM_DIGITS);

    localparam logic [CODE_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic emit_last;
        logic out_free;
    } sts_t;

    // Add 3 to a BCD digit of 5 or more ahead of a left shift.
    function automatic logic [3:0] dabble_adj(input logic [3:0] dig);
        dabble_adj = (dig >= 4'd5) ? dig + 4'd3 : dig;
    endfunction

endpackage

### hw/rtl/sida_ctrl.sv
// Controller state machine: sequences accept, conversion, prep and character emit.
module sida_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  sida_pkg::sts_t  sts,
    output sida_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (sts.conv_last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A new request is only taken once the previous text is fully queued.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_CONV)
        else $error("load outside idle");

    // Prep directly follows the last conversion step.
    a_conv_to_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && sts.conv_last) |=> cmd.prep)
        else $error("prep did not follow conversion");
`endif

endmodule

### hw/rtl/sida_dp.sv
// Datapath: magnitude, double-dabble BCD conversion, digit selection and output register.
module sida_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sida_pkg::cmd_t                      cmd,
    output sida_pkg::sts_t                      sts,
    input  logic [sida_pkg::TDATA_IN_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sida_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                m_tlast
);

    logic [sida_pkg::VALUE_W-1:0] mag_reg;
    logic [sida_pkg::VALUE_W-1:0] mag_next;
    logic [sida_pkg::BCD_W-1:0]   bcd_reg;
    logic [sida_pkg::BCD_W-1:0]   bcd_next;
    sida_pkg::step_t              step_reg;
    sida_pkg::idx_t               idx_reg;
    sida_pkg::idx_t               top_idx;
    logic                         neg_reg;
    logic                         sign_pend_reg;
    logic [sida_pkg::CODE_W-1:0]  code_reg;
    logic                         last_reg;
    logic                         valid_reg;
    logic [3:0]                   cur_digit;
    logic                         in_neg;

    assign in_neg = s_tdata[sida_pkg::VALUE_W-1];

    // Four shift-and-adjust steps of the double-dabble per cycle.
    always_comb begin
        logic [sida_pkg::BCD_W-1:0]   b;
        logic [sida_pkg::VALUE_W-1:0] m;
        b = bcd_reg;
        m = mag_reg;
        for (int s = 0; s < sida_pkg::BITS_PER_STEP; s++) begin
            for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
                b[d*4 +: 4] = sida_pkg::dabble_adj(b[d*4 +: 4]);
            end
            b = {b[sida_pkg::BCD_W-2:0], m[sida_pkg::VALUE_W-1]};
            m = {m[sida_pkg::VALUE_W-2:0], 1'b0};
        end
        bcd_next = b;
        mag_next = m;
    end

    // Highest nonzero digit; zero keeps a single digit.
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] != 4'd0) begin
                top_idx = sida_pkg::idx_t'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    assign sts.conv_last = (step_reg == sida_pkg::step_t'(sida_pkg::NUM_STEPS - 1));
    assign sts.emit_last = !sign_pend_reg && (idx_reg == '0);
    assign sts.out_free  = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            if (cmd.load) begin
                neg_reg <= in_neg;
            end
            if (cmd.prep) begin
                sign_pend_reg <= neg_reg;
            end else if (cmd.emit) begin
                sign_pend_reg <= 1'b0;
            end
            if (cmd.emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg  <= in_neg ? (sida_pkg::VALUE_W'(0) - s_tdata) : s_tdata;
            bcd_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.step) begin
            mag_reg  <= mag_next;
            bcd_reg  <= bcd_next;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.prep) begin
            idx_reg <= top_idx;
        end else if (cmd.emit && !sign_pend_reg && idx_reg != '0) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.emit) begin
            if (sign_pend_reg) begin
                code_reg <= sida_pkg::CODE_MINUS;
                last_reg <= 1'b0;
            end else begin
                code_reg <= sida_pkg::CODE_ZERO + {2'b00, cur_digit};
                last_reg <= (idx_reg == '0);
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(sida_pkg::TDATA_OUT_W - sida_pkg::CODE_W){1'b0}}, code_reg};
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    // Never overwrite a character that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |-> !cmd.emit)
        else $error("output register overwritten");

    // The leading digit is nonzero unless the number is zero.
    a_no_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.prep |=> (idx_reg == '0 || cur_digit != 4'd0))
        else $error("leading zero selected");

    // A pending sign belongs to a negative input.
    a_sign_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        sign_pend_reg |-> neg_reg)
        else $error("sign pending for nonnegative value");

    // The minus sign goes out first and never ends the text.
    a_minus_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sign_pend_reg) |=>
            (valid_reg && code_reg == sida_pkg::CODE_MINUS && !last_reg))
        else $error("bad sign character");
`endif

endmodule

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Sequence: request accepted in idle, then conversion and prep, then the first character
// is registered; one character per cycle after that while the receiver is ready.
// A request yields 1 to 11 characters; the request rate is set by the four-bit-per-cycle BCD
// conversion and the single output register.
// The next request is taken once the last character is queued in the output register.
// Reset (aresetn low, synchronous) returns the controller to idle and empties the output.
module signed_int_to_decimal_ascii_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] char_code, [7:6] zero
    output logic        m_tlast    // last_char
);

    sida_pkg::cmd_t cmd;
    sida_pkg::sts_t sts;

    sida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sida_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### verif/tb_top.sv
// Self-checking testbench for the signed integer to decimal ASCII unit.
module tb_top;

    localparam int TAIL_ITEMS = 60;    // final items run with no idling on either side
    localparam int LONG_HOLD  = 400;   // receiver hold-off that backs the unit up
    localparam int STALL_MAX  = 4000;  // cycles with no transfer before giving up
    localparam int RAND_ITEMS = 440;
    localparam int DRAIN_CYC  = 30;

    typedef struct packed {
        logic [sida_pkg::CODE_W-1:0] code;
        logic                        last;
    } char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logic [31:0] value_q[$];   // numbers waiting to be sent
    char_t       text_q[$];    // characters still owed by the unit

    logic s_took = 1'b0;
    logic quiet = 1'b0;
    logic hold_long = 1'b0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   err_cnt = 0;
    int   num_in = 0;
    int   neg_in = 0;
    int   chars_out = 0;
    int   run_len = 0;
    int   longest = 0;

    signed_int_to_decimal_ascii_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Append the decimal text of one number, sign first, most significant digit first.
    function automatic void push_decimal_text(input logic [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digs [sida_pkg::NUM_DIGITS];
        int          nd;
        char_t       ch;
        mag = value[31] ? (32'd0 - value) : value;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            mag      = mag / 32'd10;
            nd++;
        end while (mag != 0 && nd < sida_pkg::NUM_DIGITS);
        if (value[31]) begin
            ch.code = sida_pkg::CODE_MINUS;
            ch.last = 1'b0;
            text_q.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            ch.code = sida_pkg::CODE_ZERO + sida_pkg::CODE_W'(digs[i]);
            ch.last = (i == 0);
            text_q.push_back(ch);
        end
    endfunction

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endfunction

    // Mix of raw 32-bit patterns, values of a chosen digit count and values near edges.
    function automatic logic [31:0] pick_value();
        int          kind;
        int          d;
        longint      lo;
        longint      hi;
        longint      span;
        logic [31:0] v;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            v = $urandom;
        end else if (kind < 8) begin
            d  = $urandom_range(1, 10);
            lo = 1;
            repeat (d - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            span = hi - lo + 1;
            v = 32'(lo + (longint'({$urandom, $urandom} >> 1) % span));
            if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
        end else if (kind == 8) begin
            lo = 1;
            repeat ($urandom_range(0, 9)) lo = lo * 10;
            v = 32'(lo + $urandom_range(0, 2) - 1);
            if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
        end else begin
            if ($urandom_range(0, 1) == 1) v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            else v = 32'h8000_0000 + $urandom_range(0, 3);
        end
        return v;
    endfunction

    // Sender: present the next number after a transfer, with random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (value_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap_left <= $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= value_q.pop_front();
                s_tvalid <= 1'b1;
            end
        end
        quiet <= (value_q.size() < TAIL_ITEMS);
    end

    // Receiver: random back-pressure bursts, plus one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_long) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            hold_left <= $urandom_range(0, 17);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted character.
    always @(posedge aclk) begin
        char_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                push_decimal_text(s_tdata);
                num_in++;
                if (s_tdata[31]) neg_in++;
            end
            if (m_tvalid && m_tready) begin
                chars_out++;
                run_len++;
                if (m_tlast) begin
                    if (run_len > longest) longest = run_len;
                    run_len = 0;
                end
                if (text_q.size() == 0) begin
                    note_error($sformatf("unexpected char tdata=%h tlast=%b", m_tdata, m_tlast));
                end else begin
                    want = text_q.pop_front();
                    if (m_tdata != {2'b00, want.code} || m_tlast != want.last)
                        note_error($sformatf("char %0d: expected tdata=%h tlast=%b, got %h %b",
                                             chars_out, {2'b00, want.code}, want.last,
                                             m_tdata, m_tlast));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Long receiver hold-off once traffic is flowing; the unit must stall its input.
    initial begin
        while (num_in < 40) @(negedge aclk);
        hold_long <= 1'b1;
        repeat (LONG_HOLD) @(negedge aclk);
        hold_long <= 1'b0;
    end

    initial begin
        while (idle_cycles < STALL_MAX) @(negedge aclk);
        $display("timeout: no transfer for %0d cycles", STALL_MAX);
        $display("FAIL signed_int_to_decimal_ascii_unit");
        $finish;
    end

    initial begin
        value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
                    32'd99, 32'd100, -32'sd100, 32'd12345, 32'd999999999,
                    32'd1000000000, -32'sd1000000000, 32'd1000000001,
                    32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
        repeat (RAND_ITEMS) value_q.push_back(pick_value());

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (value_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (text_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);

        if (text_q.size() != 0) note_error($sformatf("%0d chars never arrived", text_q.size()));
        $display("Converted %0d numbers (%0d negative) into %0d chars, longest text %0d.",
                 num_in, neg_in, chars_out, longest);
        $display("Idle bursts on both sides, one %0d-cycle receiver hold-off, quiet tail.",
                 LONG_HOLD);
        if (err_cnt == 0) begin
            $display("PASS signed_int_to_decimal_ascii_unit");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("FAIL signed_int_to_decimal_ascii_unit");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/sida_pkg.sv
hw/rtl/sida_ctrl.sv
hw/rtl/sida_dp.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
verif/tb_top.sv
